[rtl/rcw_pkg.sv]
// ----------------------------------------------------------------------------
// Raised-cosine window generator package
// Shared widths, polynomial coefficients and register indexes.
// ----------------------------------------------------------------------------
package rcw_pkg;

  localparam int IDX_W   = 15;  // sample index
  localparam int LEN_W   = 16;  // window length and block offset
  localparam int GIDX_W  = 31;  // global index
  localparam int PHASE_W = 16;  // phase, fraction of one turn
  localparam int Q_W     = 17;  // quarter-wave argument, Q16 up to 1.0
  localparam int ACC_W   = 31;  // Horner accumulator, Q30
  localparam int PROD_W  = 62;  // Horner product
  localparam int COS_W   = 16;  // signed Q14 cosine
  localparam int COEF_W  = 15;  // window weights
  localparam int RAW_W   = 30;  // raw window value, Q29 up to 1.0

  localparam int HORNER_CELLS = 5;

  typedef logic [ACC_W-1:0] coef_t;
  typedef coef_t horner_coef_t [HORNER_CELLS];

  // Odd sine polynomial, highest order first.
  localparam horner_coef_t HORNER_COEF = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  localparam logic [COEF_W-1:0] HANN_A    = 15'd16384;
  localparam logic [COEF_W-1:0] HANN_B    = 15'd16384;
  localparam logic [COEF_W-1:0] HAMMING_A = 15'd17695;
  localparam logic [COEF_W-1:0] HAMMING_B = 15'd15073;

  typedef enum logic [1:0] {
    CFG_KIND   = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_reg_e;

endpackage

[rtl/raised_cosine_window_gen_unit.sv]
// ----------------------------------------------------------------------------
// Raised-cosine window generator
// Returns one normalised Hann or Hamming window point per request.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the rows
// of divider cells for the phase and the normalisation and the Horner cell row
// each take one step per cycle when their stage is enabled.
// Reset clears all pipeline valid flags and sets Hann, length 512, offset 0.
// ----------------------------------------------------------------------------
module raised_cosine_window_gen_unit #(
  parameter int MAX_LENGTH = 32768,
  parameter int AMP_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [rcw_pkg::IDX_W-1:0]  sample_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rcw_pkg::GIDX_W-1:0] global_index_o,
  output logic [AMP_BITS-1:0]        amplitude_o,
  output logic                       out_of_range_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [rcw_pkg::LEN_W-1:0]  cfg_data_i
);

  localparam int S_PHASE = 1;
  localparam int S_QUAD  = S_PHASE + rcw_pkg::PHASE_W;
  localparam int S_HORN  = S_QUAD + 1;
  localparam int S_MAG   = S_HORN + rcw_pkg::HORNER_CELLS;
  localparam int S_RAW   = S_MAG + 1;
  localparam int S_NORM  = S_RAW + 1;
  localparam int S_NDIV  = S_NORM + 1;
  localparam int S_OUT   = S_NDIV + AMP_BITS;
  localparam int STAGES  = S_OUT + 1;
  localparam logic [AMP_BITS-1:0] AMP_ONE = AMP_BITS'(1) << (AMP_BITS - 1);

  typedef struct packed {
    logic                       oor;
    logic [rcw_pkg::GIDX_W-1:0] gidx;
  } phase_side_t;

  typedef struct packed {
    logic                      neg;
    logic [rcw_pkg::Q_W-1:0]   q;
    logic [rcw_pkg::ACC_W-1:0] q2;
  } arg_t;

  typedef struct packed {
    logic                       oor;
    logic [rcw_pkg::GIDX_W-1:0] gidx;
    arg_t                       arg;
  } horn_side_t;

  typedef struct packed {
    logic                       oor;
    logic                       force_one;
    logic [rcw_pkg::RAW_W-1:0]  pk;
    logic [AMP_BITS-1:0]        low;
    logic [rcw_pkg::GIDX_W-1:0] gidx;
  } norm_side_t;

  // Configuration registers
  logic                      kind_q;
  logic [rcw_pkg::LEN_W-1:0] len_q;
  logic [rcw_pkg::LEN_W-1:0] off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
      len_q  <= 16'd512;
      off_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcw_pkg::CFG_KIND: begin
          kind_q <= cfg_data_i[0];
        end
        rcw_pkg::CFG_LENGTH: begin
          if ({1'b0, cfg_data_i} > 17'(MAX_LENGTH)) begin
            len_q <= rcw_pkg::LEN_W'(MAX_LENGTH);
          end else begin
            len_q <= cfg_data_i;
          end
        end
        rcw_pkg::CFG_OFFSET: begin
          off_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its content moves on.
  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] en;

  assign en[STAGES-1] = !v_q[STAGES-1] || !out_stall_i;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Entry stage
  logic [rcw_pkg::LEN_W-1:0]  idx_q;
  logic [rcw_pkg::LEN_W-1:0]  half_q;
  phase_side_t                entry_q;
  logic [2*rcw_pkg::LEN_W-1:0] base;

  assign base = off_q * len_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      idx_q        <= {1'b0, sample_index_i};
      half_q       <= len_q >> 1;
      entry_q.oor  <= ({1'b0, sample_index_i} >= len_q);
      entry_q.gidx <= rcw_pkg::GIDX_W'(base + 32'(sample_index_i));
    end
  end

  // Phase division, value lane (a) and peak lane (b)
  logic [rcw_pkg::LEN_W-1:0]   rema [rcw_pkg::PHASE_W+1];
  logic [rcw_pkg::LEN_W-1:0]   remb [rcw_pkg::PHASE_W+1];
  logic [rcw_pkg::PHASE_W-1:0] quoa [rcw_pkg::PHASE_W+1];
  logic [rcw_pkg::PHASE_W-1:0] quob [rcw_pkg::PHASE_W+1];
  phase_side_t                 psa  [rcw_pkg::PHASE_W+1];
  logic                        psb  [rcw_pkg::PHASE_W+1];

  assign rema[0] = idx_q;
  assign remb[0] = half_q;
  assign quoa[0] = '0;
  assign quob[0] = '0;
  assign psa[0]  = entry_q;
  assign psb[0]  = entry_q.oor;

  for (genvar k = 0; k < rcw_pkg::PHASE_W; k++) begin : g_phase
    rcw_div_cell #(
      .DW(rcw_pkg::LEN_W), .QW(rcw_pkg::PHASE_W), .SW($bits(phase_side_t))
    ) u_cell_a (
      .clk_i(clk_i), .en_i(en[S_PHASE+k]), .divisor_i(len_q), .rem_i(rema[k]),
      .bit_i(1'b0), .quo_i(quoa[k]), .side_i(psa[k]),
      .rem_o(rema[k+1]), .quo_o(quoa[k+1]), .side_o(psa[k+1])
    );
    rcw_div_cell #(
      .DW(rcw_pkg::LEN_W), .QW(rcw_pkg::PHASE_W), .SW(1)
    ) u_cell_b (
      .clk_i(clk_i), .en_i(en[S_PHASE+k]), .divisor_i(len_q), .rem_i(remb[k]),
      .bit_i(1'b0), .quo_i(quob[k]), .side_i(psb[k]),
      .rem_o(remb[k+1]), .quo_o(quob[k+1]), .side_o(psb[k+1])
    );
  end

  // Quadrant folding: cosine becomes a signed quarter-wave sine.
  function automatic arg_t fold(input logic [rcw_pkg::PHASE_W-1:0] p);
    arg_t                     a;
    logic [13:0]              r;
    logic [2*rcw_pkg::Q_W-1:0] sq;
    r = p[13:0];
    if (p[14]) begin
      a.q = {1'b0, r, 2'b00};
    end else begin
      a.q = rcw_pkg::Q_W'((17'd16384 - {3'b000, r}) << 2);
    end
    a.neg = p[15] ^ p[14];
    sq    = a.q * a.q;
    a.q2  = sq[32:2];
    return a;
  endfunction

  horn_side_t quad_a_q;
  arg_t       quad_b_q;

  always_ff @(posedge clk_i) begin
    if (en[S_QUAD]) begin
      quad_a_q.oor  <= psa[rcw_pkg::PHASE_W].oor;
      quad_a_q.gidx <= psa[rcw_pkg::PHASE_W].gidx;
      quad_a_q.arg  <= fold(quoa[rcw_pkg::PHASE_W]);
      quad_b_q      <= fold(quob[rcw_pkg::PHASE_W]);
    end
  end

  // Horner polynomial
  logic [rcw_pkg::PROD_W-1:0] proda [rcw_pkg::HORNER_CELLS+1];
  logic [rcw_pkg::PROD_W-1:0] prodb [rcw_pkg::HORNER_CELLS+1];
  horn_side_t                 hsa   [rcw_pkg::HORNER_CELLS+1];
  arg_t                       hsb   [rcw_pkg::HORNER_CELLS+1];

  assign proda[0] = '0;
  assign prodb[0] = '0;
  assign hsa[0]   = quad_a_q;
  assign hsb[0]   = quad_b_q;

  for (genvar h = 0; h < rcw_pkg::HORNER_CELLS; h++) begin : g_horner
    logic [rcw_pkg::ACC_W-1:0] multa;
    logic [rcw_pkg::ACC_W-1:0] multb;
    // The last step multiplies by the argument itself, the others by its square.
    assign multa = (h == rcw_pkg::HORNER_CELLS - 1) ?
                   rcw_pkg::ACC_W'(hsa[h].arg.q) : hsa[h].arg.q2;
    assign multb = (h == rcw_pkg::HORNER_CELLS - 1) ?
                   rcw_pkg::ACC_W'(hsb[h].q) : hsb[h].q2;

    rcw_horner_cell #(.SW($bits(horn_side_t))) u_cell_a (
      .clk_i(clk_i), .en_i(en[S_HORN+h]), .coef_i(rcw_pkg::HORNER_COEF[h]),
      .prod_i(proda[h]), .mult_i(multa), .side_i(hsa[h]),
      .prod_o(proda[h+1]), .side_o(hsa[h+1])
    );
    rcw_horner_cell #(.SW($bits(arg_t))) u_cell_b (
      .clk_i(clk_i), .en_i(en[S_HORN+h]), .coef_i(rcw_pkg::HORNER_COEF[h]),
      .prod_i(prodb[h]), .mult_i(multb), .side_i(hsb[h]),
      .prod_o(prodb[h+1]), .side_o(hsb[h+1])
    );
  end

  // Rounding to Q14 with the sign applied
  function automatic logic signed [rcw_pkg::COS_W-1:0] to_cos(
    input logic [rcw_pkg::PROD_W-1:0] prod,
    input logic                       neg
  );
    logic [32:0]               sum;
    logic [16:0]               mag;
    logic [rcw_pkg::COS_W-1:0] m;
    sum = {1'b0, prod[47:16]} + 33'd32768;
    mag = sum[32:16];
    m   = (mag > 17'd16384) ? 16'd16384 : mag[15:0];
    return neg ? -m : m;
  endfunction

  logic signed [rcw_pkg::COS_W-1:0] cosa_q;
  logic signed [rcw_pkg::COS_W-1:0] cosb_q;
  phase_side_t                      mag_q;

  always_ff @(posedge clk_i) begin
    if (en[S_MAG]) begin
      cosa_q     <= to_cos(proda[rcw_pkg::HORNER_CELLS],
                           hsa[rcw_pkg::HORNER_CELLS].arg.neg);
      cosb_q     <= to_cos(prodb[rcw_pkg::HORNER_CELLS],
                           hsb[rcw_pkg::HORNER_CELLS].neg);
      mag_q.oor  <= hsa[rcw_pkg::HORNER_CELLS].oor;
      mag_q.gidx <= hsa[rcw_pkg::HORNER_CELLS].gidx;
    end
  end

  // Raw window value A - B*cos in Q29
  function automatic logic [rcw_pkg::RAW_W-1:0] to_raw(
    input logic                            kind,
    input logic signed [rcw_pkg::COS_W-1:0] c
  );
    logic [rcw_pkg::COEF_W-1:0] a;
    logic signed [16:0]         b;
    logic signed [32:0]         bc;
    logic signed [32:0]         v;
    a  = kind ? rcw_pkg::HAMMING_A : rcw_pkg::HANN_A;
    b  = $signed({2'b00, (kind ? rcw_pkg::HAMMING_B : rcw_pkg::HANN_B)});
    bc = b * c;
    v  = $signed({4'b0000, a, 14'd0}) - bc;
    return v[32] ? '0 : v[rcw_pkg::RAW_W-1:0];
  endfunction

  logic [rcw_pkg::RAW_W-1:0] rawa_q;
  logic [rcw_pkg::RAW_W-1:0] rawb_q;
  phase_side_t               raw_q;

  always_ff @(posedge clk_i) begin
    if (en[S_RAW]) begin
      rawa_q <= to_raw(kind_q, cosa_q);
      rawb_q <= to_raw(kind_q, cosb_q);
      raw_q  <= mag_q;
    end
  end

  // Normalisation set-up: numerator is raw * ONE plus half the peak.
  logic [rcw_pkg::RAW_W+AMP_BITS-1:0] numer;
  logic [rcw_pkg::RAW_W-1:0]          hi;
  logic [rcw_pkg::RAW_W-1:0]          hi_q;
  norm_side_t                         norm_q;

  assign numer = ({{AMP_BITS{1'b0}}, rawa_q} << (AMP_BITS - 1))
               + (rcw_pkg::RAW_W + AMP_BITS)'(rawb_q >> 1);
  assign hi    = numer[rcw_pkg::RAW_W+AMP_BITS-1:AMP_BITS];

  always_ff @(posedge clk_i) begin
    if (en[S_NORM]) begin
      hi_q             <= hi;
      norm_q.oor       <= raw_q.oor;
      norm_q.force_one <= (rawb_q == '0) || (hi >= rawb_q);
      norm_q.pk        <= rawb_q;
      norm_q.low       <= numer[AMP_BITS-1:0];
      norm_q.gidx      <= raw_q.gidx;
    end
  end

  // Normalisation division
  logic [rcw_pkg::RAW_W-1:0] nrem  [AMP_BITS+1];
  logic [AMP_BITS-1:0]       nquo  [AMP_BITS+1];
  norm_side_t                nside [AMP_BITS+1];

  assign nrem[0]  = hi_q;
  assign nquo[0]  = '0;
  assign nside[0] = norm_q;

  for (genvar k = 0; k < AMP_BITS; k++) begin : g_norm
    rcw_div_cell #(
      .DW(rcw_pkg::RAW_W), .QW(AMP_BITS), .SW($bits(norm_side_t))
    ) u_cell (
      .clk_i(clk_i), .en_i(en[S_NDIV+k]), .divisor_i(nside[k].pk),
      .rem_i(nrem[k]), .bit_i(nside[k].low[AMP_BITS-1-k]), .quo_i(nquo[k]),
      .side_i(nside[k]),
      .rem_o(nrem[k+1]), .quo_o(nquo[k+1]), .side_o(nside[k+1])
    );
  end

  // Output register
  logic [AMP_BITS-1:0] amp_d;

  always_comb begin
    if (nside[AMP_BITS].oor) begin
      amp_d = '0;
    end else if (nside[AMP_BITS].force_one || (nquo[AMP_BITS] > AMP_ONE)) begin
      amp_d = AMP_ONE;
    end else begin
      amp_d = nquo[AMP_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      amplitude_o    <= amp_d;
      global_index_o <= nside[AMP_BITS].gidx;
      out_of_range_o <= nside[AMP_BITS].oor;
    end
  end

endmodule

[rtl/rcw_div_cell.sv]
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit per cycle while enabled and hands the partial remainder on.
// ----------------------------------------------------------------------------
module rcw_div_cell #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [DW-1:0] rem_i,
  input  logic          bit_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fit;
  logic [DW-1:0] rem_d;
  logic [QW-1:0] quo_d;

  always_comb begin
    trial = {rem_i, bit_i};
    diff  = trial - {1'b0, divisor_i};
    fit   = (trial >= {1'b0, divisor_i});
    rem_d = fit ? diff[DW-1:0] : trial[DW-1:0];
    quo_d = {quo_i[QW-2:0], fit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

[rtl/rcw_horner_cell.sv]
// ----------------------------------------------------------------------------
// Horner step cell
// Subtracts the previous product from a coefficient and multiplies again.
// ----------------------------------------------------------------------------
module rcw_horner_cell #(
  parameter int SW = 1
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rcw_pkg::ACC_W-1:0] coef_i,
  input  logic [rcw_pkg::PROD_W-1:0] prod_i,
  input  logic [rcw_pkg::ACC_W-1:0] mult_i,
  input  logic [SW-1:0]             side_i,
  output logic [rcw_pkg::PROD_W-1:0] prod_o,
  output logic [SW-1:0]             side_o
);

  logic [rcw_pkg::ACC_W-1:0]  acc;
  logic [rcw_pkg::PROD_W-1:0] prod_d;

  // The previous product shifted down never exceeds the coefficient.
  always_comb begin
    acc    = coef_i - prod_i[60:30];
    prod_d = acc * mult_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= prod_d;
      side_o <= side_i;
    end
  end

endmodule
